// ===== rtl/core/dlrb_pkg.sv =====
// ============================================================================
// dlrb_pkg: shared types and constants of the daylight ramp brightness block
// Phase codes, the tag that travels with each word through the pipeline,
// register indexes, reset values and the fixed constants of the ease curve.
// ============================================================================
package dlrb_pkg;

    localparam int MIN_W     = 11;
    localparam int HOUR_W    = 5;
    localparam int MINUTE_W  = 6;
    localparam int CH_IDX_W  = 3;
    localparam int LEVEL_W   = 7;
    localparam int PEAK_W    = 8;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        PH_OFF  = 2'd0,
        PH_RISE = 2'd1,
        PH_PEAK = 2'd2,
        PH_SET  = 2'd3
    } t_phase;

    typedef struct packed {
        logic   valid;
        t_phase phase;
    } t_tag;

    typedef logic [MIN_W-1:0] t_minute;

    typedef struct packed {
        t_minute on_min;
        t_minute peak_start;
        t_minute peak_end;
        t_minute off_min;
    } t_sched;

    localparam logic [CFG_IDX_W-1:0] REG_ON         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_START = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_END   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFF        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_TABLE = 3'd4;

    localparam t_minute RST_ON         = 11'd480;
    localparam t_minute RST_PEAK_START = 11'd600;
    localparam t_minute RST_PEAK_END   = 11'd960;
    localparam t_minute RST_OFF        = 11'd1200;

    localparam int MIN_PER_HOUR = 60;
    localparam int EASE_A_K     = 126;   // 3 * 0.42 in percent
    localparam int EASE_B_K     = 174;   // 3 * 0.58 in percent
    localparam int PCT_SCALE    = 100;
    localparam int LEVEL_MAX    = 100;

endpackage

// ===== rtl/core/dlrb_front.sv =====
// ============================================================================
// dlrb_front: minute of day and phase selection
// Two stages: the minute of day, then the phase with the elapsed time and
// the length of the ramp that the divider needs.
// ============================================================================
module dlrb_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [dlrb_pkg::HOUR_W-1:0]         i_hour,
    input  logic [dlrb_pkg::MINUTE_W-1:0]       i_minute,
    input  dlrb_pkg::t_sched                    i_sched,
    output dlrb_pkg::t_tag                      o_tag,
    output dlrb_pkg::t_minute                   o_e,
    output dlrb_pkg::t_minute                   o_d
);
    import dlrb_pkg::*;

    logic    r_a_valid;
    t_minute r_t;
    t_tag    r_tag;
    t_minute r_e;
    t_minute r_d;

    t_phase  n_phase;
    t_minute n_e;
    t_minute n_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_tag     <= '0;
        end else begin
            r_a_valid   <= i_valid;
            r_tag.valid <= r_a_valid;
            r_tag.phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t <= t_minute'(i_hour) * t_minute'(MIN_PER_HOUR) + t_minute'(i_minute);
        r_e <= n_e;
        r_d <= n_d;
    end

    // Outside a ramp the divider still runs, on a harmless 0 / 1.
    always_comb begin
        n_phase = PH_OFF;
        n_e     = '0;
        n_d     = t_minute'(1);
        if (r_t < i_sched.on_min || r_t >= i_sched.off_min) begin
            n_phase = PH_OFF;
        end else if (r_t < i_sched.peak_start) begin
            n_phase = PH_RISE;
            n_e     = r_t - i_sched.on_min;
            n_d     = i_sched.peak_start - i_sched.on_min;
        end else if (r_t < i_sched.peak_end) begin
            n_phase = PH_PEAK;
        end else begin
            n_phase = PH_SET;
            n_e     = r_t - i_sched.peak_end;
            n_d     = i_sched.off_min - i_sched.peak_end;
        end
    end

    assign o_tag = r_tag;
    assign o_e   = r_e;
    assign o_d   = r_d;

endmodule

// ===== rtl/core/dlrb_div.sv =====
// ============================================================================
// dlrb_div: pipelined restoring divider for the ramp progress
// Forms p = floor(e * 2^FRAC_BITS / d) for e < d, one quotient bit a stage.
// ============================================================================
module dlrb_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  dlrb_pkg::t_tag          i_tag,
    input  dlrb_pkg::t_minute       i_e,
    input  dlrb_pkg::t_minute       i_d,
    output dlrb_pkg::t_tag          o_tag,
    output logic [FRAC_BITS-1:0]    o_p
);
    import dlrb_pkg::*;

    t_tag                 r_tag [FRAC_BITS];
    t_minute              r_rem [FRAC_BITS];
    t_minute              r_d   [FRAC_BITS];
    logic [FRAC_BITS-1:0] r_quo [FRAC_BITS];

    for (genvar s = 0; s < FRAC_BITS; s++) begin : g_stage
        t_tag                 tag_in;
        t_minute              rem_in;
        t_minute              d_in;
        logic [FRAC_BITS-1:0] quo_in;
        logic [MIN_W:0]       shifted;
        logic                 take;

        if (s == 0) begin : g_first
            assign tag_in = i_tag;
            assign rem_in = i_e;
            assign d_in   = i_d;
            assign quo_in = '0;
        end else begin : g_next
            assign tag_in = r_tag[s-1];
            assign rem_in = r_rem[s-1];
            assign d_in   = r_d[s-1];
            assign quo_in = r_quo[s-1];
        end

        assign shifted = {rem_in, 1'b0};
        assign take    = (shifted >= {1'b0, d_in});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[s] <= '0;
            end else begin
                r_tag[s] <= tag_in;
            end
        end

        // The remainder stays below d, so it always fits back in MIN_W bits.
        always_ff @(posedge i_clk) begin
            r_rem[s] <= take ? MIN_W'(shifted - {1'b0, d_in}) : MIN_W'(shifted);
            r_d[s]   <= d_in;
            r_quo[s] <= {quo_in[FRAC_BITS-2:0], take};
        end
    end

    assign o_tag = r_tag[FRAC_BITS-1];
    assign o_p   = r_quo[FRAC_BITS-1];

endmodule

// ===== rtl/core/dlrb_ease.sv =====
// ============================================================================
// dlrb_ease: cubic ease curve and brightness factor
// Five stages: squares, cubes and cross terms, weighted sum, reciprocal
// divide by 100, then correction, saturation and the factor for the phase.
// ============================================================================
module dlrb_ease #(
    parameter int FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  dlrb_pkg::t_tag          i_tag,
    input  logic [FRAC_BITS-1:0]    i_p,
    output dlrb_pkg::t_tag          o_tag,
    output logic [FRAC_BITS:0]      o_f
);
    import dlrb_pkg::*;

    localparam int F     = FRAC_BITS;
    localparam int ONE_W = F + 1;
    localparam int XW    = F + 9;      // 126a + 174b < 300 * 2^F
    localparam int K     = XW;
    localparam int MW    = K - 6;
    localparam int QW    = F + 2;
    localparam longint unsigned RECIP = (64'd1 << K) / PCT_SCALE;
    localparam logic [MW-1:0]    RECIP_M = MW'(RECIP);
    localparam logic [ONE_W-1:0] ONE     = {1'b1, {F{1'b0}}};

    t_tag r_tag1, r_tag2, r_tag3, r_tag4, r_tag5;

    // Stage 1
    logic [ONE_W-1:0]   n_q;
    logic [2*F-1:0]     prod_pp;
    logic [2*ONE_W-1:0] prod_qq;
    logic [F-1:0]       r1_p;
    logic [ONE_W-1:0]   r1_q;
    logic [F-1:0]       r1_p2;
    logic [ONE_W-1:0]   r1_q2;

    assign n_q     = ONE - {1'b0, i_p};
    assign prod_pp = i_p * i_p;
    assign prod_qq = n_q * n_q;

    // Stage 2
    logic [2*F-1:0]     prod_p3;
    logic [2*F:0]       prod_a;
    logic [2*F:0]       prod_b;
    logic [F-1:0]       r2_p3;
    logic [F-1:0]       r2_a;
    logic [F-1:0]       r2_b;

    assign prod_p3 = r1_p2 * r1_p;
    assign prod_a  = r1_q2 * r1_p;
    assign prod_b  = r1_q * r1_p2;

    // Stage 3
    logic [XW-1:0]      n_x;
    logic [XW-1:0]      r3_x;
    logic [F-1:0]       r3_p3;

    assign n_x = XW'(r2_a) * XW'(EASE_A_K) + XW'(r2_b) * XW'(EASE_B_K);

    // Stage 4
    logic [XW+MW-1:0]   prod_r;
    logic [QW-1:0]      r4_qh;
    logic [XW-1:0]      r4_x;
    logic [F-1:0]       r4_p3;

    assign prod_r = r3_x * RECIP_M;

    // Stage 5
    logic [XW-1:0]      back;
    logic [XW-1:0]      rem;
    logic [QW-1:0]      qd;
    logic [QW-1:0]      c_raw;
    logic [ONE_W-1:0]   c_sat;
    logic [ONE_W-1:0]   n_f;
    logic [ONE_W-1:0]   r5_f;

    // The reciprocal estimate is at most one short of the true quotient.
    assign back  = XW'(r4_qh) * XW'(PCT_SCALE);
    assign rem   = r4_x - back;
    assign qd    = r4_qh + QW'(rem >= XW'(PCT_SCALE));
    assign c_raw = qd + QW'(r4_p3);
    assign c_sat = (c_raw > QW'(ONE)) ? ONE : ONE_W'(c_raw);

    always_comb begin
        unique case (r_tag4.phase)
            PH_RISE: n_f = c_sat;
            PH_PEAK: n_f = ONE;
            PH_SET:  n_f = ONE - c_sat;
            default: n_f = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
            r_tag3 <= '0;
            r_tag4 <= '0;
            r_tag5 <= '0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
            r_tag3 <= r_tag2;
            r_tag4 <= r_tag3;
            r_tag5 <= r_tag4;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_p  <= i_p;
        r1_q  <= n_q;
        r1_p2 <= prod_pp[2*F-1:F];
        r1_q2 <= prod_qq[2*F:F];
        r2_p3 <= prod_p3[2*F-1:F];
        r2_a  <= prod_a[2*F-1:F];
        r2_b  <= prod_b[2*F-1:F];
        r3_x  <= n_x;
        r3_p3 <= r2_p3;
        r4_qh <= prod_r[K+QW-1:K];
        r4_x  <= r3_x;
        r4_p3 <= r3_p3;
        r5_f  <= n_f;
    end

    assign o_tag = r_tag5;
    assign o_f   = r5_f;

endmodule

// ===== rtl/core/dlrb_chan.sv =====
// ============================================================================
// dlrb_chan: channel sequencer and output register
// Steps through the channels one a cycle, scales each peak by the factor,
// clamps to 100 and drives the registered result word.
// ============================================================================
module dlrb_chan #(
    parameter int CHANNELS  = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dlrb_pkg::t_tag                    i_tag,
    input  logic [FRAC_BITS:0]                i_f,
    input  logic [dlrb_pkg::CFG_W-1:0]        i_peak_table,
    output logic                              o_valid,
    output logic [dlrb_pkg::CH_IDX_W-1:0]     o_channel_index,
    output logic [dlrb_pkg::LEVEL_W-1:0]      o_level,
    output logic [1:0]                        o_phase,
    output logic                              o_any_on,
    output logic                              o_last
);
    import dlrb_pkg::*;

    localparam int CNT_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CNT_W-1:0] LAST_CH = CNT_W'(CHANNELS - 1);
    localparam int PROD_W = PEAK_W + FRAC_BITS + 1;

    logic               r_act;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_any;
    logic [FRAC_BITS:0] r_f;
    t_phase             r_phase;

    logic               is_last;
    logic [PEAK_W-1:0]  pk;
    logic [PROD_W-1:0]  prod;
    logic [PEAK_W:0]    lv_raw;
    logic [LEVEL_W-1:0] lv;
    logic               any_now;

    assign is_last = (r_cnt == LAST_CH);
    assign pk      = i_peak_table[{r_cnt, 3'b000} +: PEAK_W];
    assign prod    = pk * r_f;
    assign lv_raw  = prod[PROD_W-1:FRAC_BITS];
    assign lv      = (lv_raw > (PEAK_W+1)'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX)
                                                        : LEVEL_W'(lv_raw);
    assign any_now = r_any | (lv != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act   <= 1'b0;
            r_cnt   <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_act;
            if (i_tag.valid) begin
                r_act <= 1'b1;
                r_cnt <= '0;
            end else if (r_act) begin
                if (is_last) begin
                    r_act <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tag.valid) begin
            r_f     <= i_f;
            r_phase <= i_tag.phase;
            r_any   <= 1'b0;
        end else if (r_act) begin
            r_any   <= any_now;
        end
        o_channel_index <= CH_IDX_W'(r_cnt);
        o_level         <= lv;
        o_phase         <= r_phase;
        o_any_on        <= is_last & any_now;
        o_last          <= is_last;
    end

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tag.valid |-> (!r_act || is_last))
        else $error("new word reached the sequencer before the last channel");

    a_any_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_any_on) |-> o_last)
        else $error("any_on raised on a word that is not the last");

    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == (o_channel_index == CH_IDX_W'(CHANNELS - 1))))
        else $error("last flag does not match the final channel");

    a_off_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_phase == PH_OFF) |-> (o_level == '0))
        else $error("nonzero level while off");

    a_run_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> o_valid)
        else $error("result run broke off before the last channel");
`endif

endmodule

// ===== rtl/core/daylight_ramp_brightness.sv =====
// ============================================================================
// daylight_ramp_brightness: daylight schedule with an eased brightness ramp
// Turns an hour and minute into one brightness word per LED channel.
// ============================================================================
// A command is taken at a rising edge where start is high and busy is low.
// Each command produces CHANNELS result words, channel 0 first, on
// consecutive cycles, each marked by o_valid for exactly one cycle; the
// receiver must take every word as it comes, since it cannot stall the block.
// After an accepted command busy stays high until the single channel
// sequencer at the end of the pipeline is free again, since it emits one
// word per cycle. Commands overlap inside the pipeline, so a new command
// is taken while earlier ones are still being worked on. On its way to
// the outputs the word for channel 0 passes the front end, which forms the
// minute of day and the phase, then the progress divider, which retires
// one quotient bit per stage (FRAC_BITS stages), the five stages of the
// ease curve and last the sequencer and the output register.
// Configuration registers are written through i_cfg_we / i_cfg_idx /
// i_cfg_data and must only be changed while no command is in flight;
// unknown indexes are ignored.
//
// The phase is off before on_minute or from off_minute on, sunrise before
// peak_start_minute, peak before peak_end_minute and sunset after that. In
// the ramps the progress runs through the cubic ease curve in fixed point
// with FRAC_BITS fraction bits, and each channel's peak byte is scaled by it
// (by its complement at sunset). Every level is clamped to 100 percent. The
// last word of a command carries any_on, set when some channel is lit.
// ============================================================================
module daylight_ramp_brightness #(
    parameter int CHANNELS  = 4,
    parameter int FRAC_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [dlrb_pkg::HOUR_W-1:0]       i_hour_of_day,
    input  logic [dlrb_pkg::MINUTE_W-1:0]     i_minute_of_hour,
    input  logic                              i_cfg_we,
    input  logic [dlrb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [dlrb_pkg::CFG_W-1:0]        i_cfg_data,
    output logic                              o_valid,
    output logic [dlrb_pkg::CH_IDX_W-1:0]     o_channel_index,
    output logic [dlrb_pkg::LEVEL_W-1:0]      o_level,
    output logic [1:0]                        o_phase,
    output logic                              o_any_on,
    output logic                              o_last
);
    import dlrb_pkg::*;

    localparam int GAP_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Schedule and peak registers.
    t_sched           r_sched;
    logic [CFG_W-1:0] r_peak_table;

    // Spacing counter: counts down the cycles until the sequencer is free.
    logic [GAP_W-1:0] r_gap;
    logic             accept;

    // Pipeline links between the stages.
    t_tag                 front_tag;
    t_minute              front_e;
    t_minute              front_d;
    t_tag                 div_tag;
    logic [FRAC_BITS-1:0] div_p;
    t_tag                 ease_tag;
    logic [FRAC_BITS:0]   ease_f;

    assign busy   = (r_gap != '0);
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= '0;
        end else if (accept) begin
            r_gap <= GAP_W'(CHANNELS - 1);
        end else if (r_gap != '0) begin
            r_gap <= r_gap - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sched.on_min     <= RST_ON;
            r_sched.peak_start <= RST_PEAK_START;
            r_sched.peak_end   <= RST_PEAK_END;
            r_sched.off_min    <= RST_OFF;
            r_peak_table       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ON:         r_sched.on_min     <= i_cfg_data[MIN_W-1:0];
                REG_PEAK_START: r_sched.peak_start <= i_cfg_data[MIN_W-1:0];
                REG_PEAK_END:   r_sched.peak_end   <= i_cfg_data[MIN_W-1:0];
                REG_OFF:        r_sched.off_min    <= i_cfg_data[MIN_W-1:0];
                REG_PEAK_TABLE: r_peak_table       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Minute of day and phase.
    dlrb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (accept),
        .i_hour   (i_hour_of_day),
        .i_minute (i_minute_of_hour),
        .i_sched  (r_sched),
        .o_tag    (front_tag),
        .o_e      (front_e),
        .o_d      (front_d)
    );

    // Ramp progress, one quotient bit per stage.
    dlrb_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (front_tag),
        .i_e     (front_e),
        .i_d     (front_d),
        .o_tag   (div_tag),
        .o_p     (div_p)
    );

    // Ease curve and the brightness factor for the phase.
    dlrb_ease #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ease (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (div_tag),
        .i_p     (div_p),
        .o_tag   (ease_tag),
        .o_f     (ease_f)
    );

    // One word per channel.
    dlrb_chan #(
        .CHANNELS  (CHANNELS),
        .FRAC_BITS (FRAC_BITS)
    ) u_chan (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_tag           (ease_tag),
        .i_f             (ease_f),
        .i_peak_table    (r_peak_table),
        .o_valid         (o_valid),
        .o_channel_index (o_channel_index),
        .o_level         (o_level),
        .o_phase         (o_phase),
        .o_any_on        (o_any_on),
        .o_last          (o_last)
    );

endmodule

// ===== test/daylight_ramp_brightness_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// daylight_ramp_brightness_test: self-checking bench for the daylight ramp
// Sends hour/minute commands under several schedules and peak tables. Every
// result word is compared against a local fixed-point model of the eased ramp.
// ============================================================================
module daylight_ramp_brightness_test;

    import dlrb_pkg::*;

    localparam int CHANNELS     = 4;
    localparam int FRAC_BITS    = 16;
    localparam int PIPE_LATENCY = FRAC_BITS + 8;
    localparam int QUIET_LIMIT  = 5000;
    localparam int REPORT_MAX   = 10;
    localparam int PHASE_ITEMS  = 26;
    localparam int RANDOM_RUNS  = 6;
    localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;

    // Indexes beyond the last register; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
    } t_clock_reading;

    typedef struct packed {
        logic [CH_IDX_W-1:0] channel;
        logic [LEVEL_W-1:0]  level;
        t_phase              phase;
        logic                any_on;
        logic                last;
    } t_brightness_word;

    logic                 i_clk            = 1'b0;
    logic                 i_rst_n          = 1'b0;
    logic                 start            = 1'b0;
    logic                 busy;
    logic [HOUR_W-1:0]    i_hour_of_day    = '0;
    logic [MINUTE_W-1:0]  i_minute_of_hour = '0;
    logic                 i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx        = '0;
    logic [CFG_W-1:0]     i_cfg_data       = '0;
    logic                 o_valid;
    logic [CH_IDX_W-1:0]  o_channel_index;
    logic [LEVEL_W-1:0]   o_level;
    logic [1:0]           o_phase;
    logic                 o_any_on;
    logic                 o_last;

    daylight_ramp_brightness #(
        .CHANNELS  (CHANNELS),
        .FRAC_BITS (FRAC_BITS)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_hour_of_day    (i_hour_of_day),
        .i_minute_of_hour (i_minute_of_hour),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_valid          (o_valid),
        .o_channel_index  (o_channel_index),
        .o_level          (o_level),
        .o_phase          (o_phase),
        .o_any_on         (o_any_on),
        .o_last           (o_last)
    );

    // Local copy of the configuration registers, kept in step with every
    // write. Writes only happen while no command is in flight, so the copy
    // seen at the accepting edge is the one the block uses for that command.
    t_minute     sched_on         = RST_ON;
    t_minute     sched_peak_start = RST_PEAK_START;
    t_minute     sched_peak_end   = RST_PEAK_END;
    t_minute     sched_off        = RST_OFF;
    logic [63:0] peak_bytes       = '0;

    t_clock_reading   pending_readings[$];
    t_brightness_word expected_words[$];

    int               sender_idle_pct = 0;
    int               failures        = 0;
    int               quiet_cycles    = 0;
    t_clock_reading   next_reading;
    t_brightness_word want;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Model of the eased ramp. Progress is the elapsed part of the ramp in
    // Q0.FRAC_BITS; the cubic ease uses the control points 0.42 and 0.58,
    // which show up as the weights 126 and 174 over a scale of 100. Every
    // shift truncates, and the curve is capped at one.
    // ------------------------------------------------------------------------
    function automatic logic [63:0] eased_progress(input logic [63:0] elapsed,
                                                   input logic [63:0] span);
        logic [63:0] p, q, p2, p3, q2, a, b, c;
        p = (elapsed << FRAC_BITS) / span;
        if (p > ONE_Q) p = ONE_Q;
        q  = ONE_Q - p;
        p2 = (p * p) >> FRAC_BITS;
        p3 = (p2 * p) >> FRAC_BITS;
        q2 = (q * q) >> FRAC_BITS;
        a  = (q2 * p) >> FRAC_BITS;
        b  = (q * p2) >> FRAC_BITS;
        c  = (64'(EASE_A_K) * a + 64'(EASE_B_K) * b + 64'(PCT_SCALE) * p3)
             / 64'(PCT_SCALE);
        if (c > ONE_Q) c = ONE_Q;
        return c;
    endfunction

    // Works out the CHANNELS words that one accepted command must produce and
    // queues them, channel 0 first. Out-of-range hours and minutes are used
    // as given; the phase comparisons alone decide where the minute falls.
    task automatic predict_channel_levels(input logic [HOUR_W-1:0] hour,
                                          input logic [MINUTE_W-1:0] minute);
        logic [63:0]      t, c, pk, lv;
        t_phase           ph;
        logic             lit;
        t_brightness_word w;
        t   = 64'(hour) * 64'(MIN_PER_HOUR) + 64'(minute);
        c   = '0;
        lit = 1'b0;
        if (t < 64'(sched_on) || t >= 64'(sched_off)) begin
            ph = PH_OFF;
        end else if (t < 64'(sched_peak_start)) begin
            ph = PH_RISE;
            c  = eased_progress(t - 64'(sched_on),
                                64'(sched_peak_start) - 64'(sched_on));
        end else if (t < 64'(sched_peak_end)) begin
            ph = PH_PEAK;
        end else begin
            ph = PH_SET;
            c  = eased_progress(t - 64'(sched_peak_end),
                                64'(sched_off) - 64'(sched_peak_end));
        end
        for (int k = 0; k < CHANNELS; k++) begin
            pk = (peak_bytes >> (8 * k)) & 64'hFF;
            case (ph)
                PH_RISE: lv = (pk * c) >> FRAC_BITS;
                PH_PEAK: lv = pk;
                PH_SET:  lv = (pk * (ONE_Q - c)) >> FRAC_BITS;
                default: lv = '0;
            endcase
            // Peaks above 100 percent are clamped in every phase.
            if (lv > 64'(LEVEL_MAX)) lv = 64'(LEVEL_MAX);
            if (lv != 0) lit = 1'b1;
            w.channel = CH_IDX_W'(k);
            w.level   = lv[LEVEL_W-1:0];
            w.phase   = ph;
            w.last    = (k == CHANNELS - 1);
            w.any_on  = (k == CHANNELS - 1) && lit;
            expected_words.push_back(w);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver. A command word is taken at an edge where start is high and busy
    // is low; the model runs at that edge on the values that were on the
    // ports. While the block is busy the word on the ports is held. After an
    // acceptance, or while idle, the next reading is put up unless the sender
    // chooses to idle this cycle. start is assigned once per edge, so a start
    // that stays high for back-to-back words is never dropped in between.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) predict_channel_levels(i_hour_of_day, i_minute_of_hour);
            if (!start || !busy) begin
                if (pending_readings.size() != 0 &&
                    $urandom_range(0, 99) >= sender_idle_pct) begin
                    next_reading      = pending_readings.pop_front();
                    start            <= 1'b1;
                    i_hour_of_day    <= next_reading.hour;
                    i_minute_of_hour <= next_reading.minute;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Each strobed result word is compared with the oldest expected
    // word, field by field. The receiver cannot hold results off, so every
    // strobe is taken. The watchdog counts cycles in which neither a command
    // nor a result word moves and ends the run when it gets too long.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_words.size() == 0) begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("unexpected word: ch %0d level %0d phase %0d any_on %0b last %0b",
                             o_channel_index, o_level, o_phase, o_any_on, o_last);
            end else begin
                want = expected_words.pop_front();
                if (o_channel_index !== want.channel || o_level !== want.level ||
                    o_phase !== want.phase || o_any_on !== want.any_on ||
                    o_last !== want.last) begin
                    failures++;
                    if (failures <= REPORT_MAX) begin
                        $display("mismatch exp: ch %0d lv %0d ph %0d any %0b last %0b",
                                 want.channel, want.level, want.phase,
                                 want.any_on, want.last);
                        $display("         got: ch %0d lv %0d ph %0d any %0b last %0b",
                                 o_channel_index, o_level, o_phase,
                                 o_any_on, o_last);
                    end
                end
            end
        end
        if ((start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no traffic for %0d cycles", QUIET_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers. Everything below runs from the sequencing block; it
    // looks at the queues on falling edges, where the clocked blocks above
    // have settled, and drives the configuration port on rising edges.
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_ON:         sched_on         = data[MIN_W-1:0];
            REG_PEAK_START: sched_peak_start = data[MIN_W-1:0];
            REG_PEAK_END:   sched_peak_end   = data[MIN_W-1:0];
            REG_OFF:        sched_off        = data[MIN_W-1:0];
            REG_PEAK_TABLE: peak_bytes       = data;
            default: ;
        endcase
    endtask

    task automatic release_cfg_port;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Writes all five registers. With noisy set, the unused upper bits of the
    // minute registers carry random junk, which the block must drop.
    task automatic write_schedule(input int on_m, input int ps_m, input int pe_m,
                                  input int off_m, input logic [63:0] table_bytes,
                                  input logic noisy);
        logic [63:0] junk;
        junk = noisy ? {$urandom, $urandom} : 64'd0;
        write_reg(REG_ON,         {junk[63:MIN_W], MIN_W'(on_m)});
        junk = noisy ? {$urandom, $urandom} : 64'd0;
        write_reg(REG_PEAK_START, {junk[63:MIN_W], MIN_W'(ps_m)});
        junk = noisy ? {$urandom, $urandom} : 64'd0;
        write_reg(REG_PEAK_END,   {junk[63:MIN_W], MIN_W'(pe_m)});
        junk = noisy ? {$urandom, $urandom} : 64'd0;
        write_reg(REG_OFF,        {junk[63:MIN_W], MIN_W'(off_m)});
        write_reg(REG_PEAK_TABLE, table_bytes);
        release_cfg_port();
    endtask

    task automatic push_reading(input int hour, input int minute);
        t_clock_reading r;
        r.hour   = HOUR_W'(hour);
        r.minute = MINUTE_W'(minute);
        pending_readings.push_back(r);
    endtask

    task automatic push_minute_of_day(input int t);
        push_reading(t / MIN_PER_HOUR, t % MIN_PER_HOUR);
    endtask

    // Mostly real clock readings; one in five uses the whole field range so
    // that every bit of both fields is exercised.
    task automatic push_random_reading;
        if ($urandom_range(0, 4) == 0)
            push_reading($urandom_range(0, 31), $urandom_range(0, 63));
        else
            push_reading($urandom_range(0, 23), $urandom_range(0, 59));
    endtask

    // Returns once every queued reading has been taken and every expected
    // word has come back.
    task automatic wait_drained;
        do @(negedge i_clk);
        while (pending_readings.size() != 0 || start || expected_words.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence: a directed part under fixed schedules, then random runs
    // that each pick a fresh schedule and peak table and an idle pattern.
    // ------------------------------------------------------------------------
    initial begin
        int          sched[4];
        int          tmp;
        logic [63:0] tbl;
        int          sel;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset values: default schedule with an all-zero peak table, so every
        // level is zero while the phase still follows the default schedule.
        sender_idle_pct = 0;
        push_minute_of_day(540);
        push_minute_of_day(700);
        wait_drained();

        // Peak bytes of 0, 100, 101 and 255 cover the clamp edges; the upper
        // bytes belong to channels that do not exist and must not matter.
        // The spare register indexes get junk that must be ignored.
        write_reg(REG_PEAK_TABLE, 64'h1122_3344_FF65_6400);
        for (int idx = REG_SPARE_FIRST; idx <= REG_SPARE_LAST; idx++)
            write_reg(CFG_IDX_W'(idx), '1);
        release_cfg_port();
        push_reading(0, 0);
        push_minute_of_day(479);
        push_minute_of_day(480);
        push_minute_of_day(481);
        push_minute_of_day(540);
        push_minute_of_day(599);
        push_minute_of_day(600);
        push_minute_of_day(959);
        push_minute_of_day(960);
        push_minute_of_day(1080);
        push_minute_of_day(1199);
        push_minute_of_day(1200);
        push_minute_of_day(1439);
        wait_drained();

        // Unordered schedule: peak start lies before the on minute, so the
        // sunrise ramp can never be chosen and peak follows on directly.
        write_schedule(1000, 200, 1100, 1300, 64'hFFFF_FFFF_3C64_C801, 1'b0);
        push_minute_of_day(1000);
        push_minute_of_day(1099);
        push_minute_of_day(1100);
        push_minute_of_day(1299);
        wait_drained();

        // Extremes: a sunrise over nearly the whole day and an off minute at
        // the top of the register, above every reading that the fields can hold.
        write_schedule(0, 1439, 1439, 2047, '1, 1'b0);
        push_minute_of_day(0);
        push_minute_of_day(719);
        push_minute_of_day(1438);
        push_minute_of_day(1439);
        push_reading(31, 63);
        wait_drained();

        for (int run = 0; run < RANDOM_RUNS; run++) begin
            case (run)
                1, 4:    sender_idle_pct = 61;
                3, 5:    sender_idle_pct = 33;
                default: sender_idle_pct = 0;
            endcase

            // Most runs use an ordered schedule inside the day; one in four
            // draws all four registers over their full width.
            if ($urandom_range(0, 3) == 0) begin
                for (int i = 0; i < 4; i++) sched[i] = $urandom_range(0, 2047);
            end else begin
                for (int i = 0; i < 4; i++) sched[i] = $urandom_range(0, 1439);
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3 - i; j++)
                        if (sched[j] > sched[j+1]) begin
                            tmp        = sched[j];
                            sched[j]   = sched[j+1];
                            sched[j+1] = tmp;
                        end
            end
            for (int k = 0; k < 8; k++) begin
                sel = $urandom_range(0, 4);
                case (sel)
                    0:       tbl[8*k +: 8] = 8'd0;
                    1:       tbl[8*k +: 8] = 8'd100;
                    2:       tbl[8*k +: 8] = 8'd101;
                    3:       tbl[8*k +: 8] = 8'd255;
                    default: tbl[8*k +: 8] = 8'($urandom_range(0, 255));
                endcase
            end
            write_schedule(sched[0], sched[1], sched[2], sched[3], tbl, 1'b1);

            // Halfway through, the sender holds off until the pipeline has
            // returned every word before it goes on.
            for (int n = 0; n < PHASE_ITEMS / 2; n++) push_random_reading();
            wait_drained();
            for (int n = PHASE_ITEMS / 2; n < PHASE_ITEMS; n++) push_random_reading();
            wait_drained();
        end

        // Let the pipeline run empty so that a stray word would still show.
        repeat (PIPE_LATENCY + 8) @(posedge i_clk);
        if (failures == 0 && expected_words.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
